[hdl/pot_pkg.sv]
// Package for the page ownership tracker: status, mode and register codes,
// sequencer states and the flag group passed to the ownership rule unit.
// No dependencies.
package pot_pkg;

  // Widths fixed by the interface
  localparam int CFG_W      = 52;
  localparam int CFG_IDX_W  = 3;
  localparam int PFN_W      = 52;
  localparam int COUNT_W    = 13;
  localparam int ID_W       = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PAGES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_OWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_OWN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_OWN   = 3'd4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_TRACKER = 3'd1,
    ST_REJECT     = 3'd2,
    ST_INVALID    = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  // Request modes
  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_SET   = 2'd1,
    MODE_UNSET = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_QUERY,
    S_WALK
  } state_t;

  // Flag arguments of a set or unset item, handed to the rule unit
  typedef struct packed {
    logic unset;
    logic guest_given;
    logic guest_val;
    logic dma_given;
    logic dma_val;
  } rule_req_t;

endpackage

[hdl/pot_ram.sv]
// Generic single-clock RAM: one write port and one read port with registered read.
// No dependencies.
module pot_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/pot_rule.sv]
// Ownership rule unit: applies the set or unset rules to one page record.
// Depends on pot_pkg.
module pot_rule import pot_pkg::*; #(
  parameter int OWNER_BITS = 16
) (
  input  logic [OWNER_BITS+1:0] cur_rec,
  input  logic [OWNER_BITS-1:0] who,
  input  logic [OWNER_BITS-1:0] res_own,
  input  logic [OWNER_BITS-1:0] dma_own,
  input  logic [OWNER_BITS-1:0] mon_own,
  input  rule_req_t             req,
  output logic [OWNER_BITS+1:0] new_rec,
  output status_t               status
);

  // Record layout: dma flag, guest flag, owner
  logic [OWNER_BITS-1:0] cur;
  logic                  cur_g;
  logic                  cur_d;
  logic [OWNER_BITS-1:0] nxt_own;
  logic                  nxt_g;
  logic                  nxt_d;

  assign cur   = cur_rec[OWNER_BITS-1:0];
  assign cur_g = cur_rec[OWNER_BITS];
  assign cur_d = cur_rec[OWNER_BITS+1];
  assign new_rec = {nxt_d, nxt_g, nxt_own};

  // Rule evaluation; the reserved rule takes priority over the DMA rule,
  // which takes priority over the monitor rule.
  always_comb begin
    nxt_own = cur;
    nxt_g   = cur_g;
    nxt_d   = cur_d;
    status  = ST_OK;
    if (!req.unset) begin
      if (who == res_own) begin
        if (cur != res_own) begin
          status = ST_REJECT;
        end else if (!(req.dma_given && req.dma_val)) begin
          status = ST_INVALID;
        end else begin
          nxt_d = 1'b1;
        end
      end else if (who == dma_own) begin
        if (cur != who) begin
          if (cur != res_own) begin
            status = ST_REJECT;
          end else begin
            nxt_own = who;
          end
        end
      end else if (who == mon_own) begin
        if (cur != res_own && cur != who) begin
          status = ST_REJECT;
        end else begin
          nxt_own = who;
        end
      end else if (who == cur) begin
        nxt_g = 1'b1;
      end else if (cur == res_own) begin
        if (!(req.guest_given && req.guest_val)) begin
          status = ST_INVALID;
        end else begin
          nxt_own = who;
          nxt_g   = 1'b1;
        end
      end else begin
        status = ST_REJECT;
      end
    end else begin
      if (who == res_own) begin
        if (cur != res_own) begin
          status = ST_REJECT;
        end else if (!(req.dma_given && !req.dma_val)) begin
          status = ST_INVALID;
        end else begin
          nxt_d = 1'b0;
        end
      end else if (who == dma_own || who == mon_own) begin
        if (cur != who) begin
          status = ST_REJECT;
        end else begin
          nxt_own = res_own;
          nxt_g   = 1'b0;
          nxt_d   = 1'b0;
        end
      end else if (who == cur && req.guest_given && !req.guest_val) begin
        nxt_own = res_own;
        nxt_g   = 1'b0;
      end else if (cur == res_own) begin
        if (!(req.guest_given && !req.guest_val)) begin
          status = ST_INVALID;
        end else begin
          nxt_g = 1'b0;
        end
      end else begin
        status = ST_REJECT;
      end
    end
  end

endmodule

[hdl/page_ownership_tracker_core.sv]
// Page ownership tracker, top level: configuration registers, sequencer and
// record store. Depends on pot_pkg, pot_ram and pot_rule.
// A query passes through the check and query states before its result; a set
// or unset run passes through the check state and then walks its pages, and
// ends early if a page fails or the item is answered before the walk starts.
// One page per cycle through the single rule unit and the store's read and
// write ports; busy falls in the cycle of the result strobe, when the next
// item can be accepted. After reset a clearing pass writes zero to every
// record, with busy high.
module page_ownership_tracker_core import pot_pkg::*; #(
  parameter int TRACKED_PAGES = 4096,
  parameter int OWNER_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Request
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [PFN_W-1:0]     page_frame,
  input  logic [COUNT_W-1:0]   page_count,
  input  logic [ID_W-1:0]      owner_id,
  input  logic                 guest_flag_given,
  input  logic                 guest_flag,
  input  logic                 dma_flag_given,
  input  logic                 dma_flag,
  // Result
  output logic                 done,
  output logic [2:0]           status,
  output logic                 guest_mapped,
  output logic                 dma_mapped,
  output logic [ID_W-1:0]      owner
);

  localparam int AW    = (TRACKED_PAGES > 1) ? $clog2(TRACKED_PAGES) : 1;
  localparam int LW_TP = $clog2(TRACKED_PAGES + 1);
  localparam int LW    = (LW_TP > COUNT_W) ? LW_TP : COUNT_W;
  localparam int RW    = OWNER_BITS + 2;

  // Configuration registers
  logic [PFN_W-1:0]      window_base_page;
  logic [COUNT_W-1:0]    window_pages;
  logic [OWNER_BITS-1:0] reserved_owner;
  logic [OWNER_BITS-1:0] dma_owner;
  logic [OWNER_BITS-1:0] monitor_owner;

  // Latched item
  logic [1:0]            req_mode;
  logic [PFN_W-1:0]      req_pfn;
  logic [OWNER_BITS-1:0] req_who;
  rule_req_t             req_flags;

  // Sequencer
  state_t                state;
  state_t                state_next;
  logic [LW-1:0]         idx;
  logic [LW-1:0]         idx_next;
  logic [COUNT_W-1:0]    remain;
  logic [COUNT_W-1:0]    remain_next;
  logic                  done_next;
  status_t               status_next;
  logic                  guest_next;
  logic                  dma_next;
  logic [ID_W-1:0]       owner_next;

  // Store and rule unit
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [RW-1:0]         rule_rec;
  status_t               rule_status;

  // Window arithmetic
  logic [LW-1:0]         live;
  logic [PFN_W:0]        diff;
  logic [PFN_W-1:0]      off;
  logic                  in_win;
  logic [LW-1:0]         idx_inc;
  logic                  accept;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign live    = (LW'(window_pages) > LW'(TRACKED_PAGES)) ? LW'(TRACKED_PAGES)
                                                            : LW'(window_pages);
  assign diff    = {1'b0, req_pfn} - {1'b0, window_base_page};
  assign off     = diff[PFN_W-1:0];
  assign in_win  = !diff[PFN_W] && (off[PFN_W-1:LW] == '0) && (off[LW-1:0] < live);
  assign idx_inc = idx + LW'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base_page <= '0;
      window_pages     <= '0;
      reserved_owner   <= OWNER_BITS'(0);
      dma_owner        <= OWNER_BITS'(1);
      monitor_owner    <= OWNER_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PAGE:    window_base_page <= cfg_data[PFN_W-1:0];
        REG_WINDOW_PAGES: window_pages     <= cfg_data[COUNT_W-1:0];
        REG_RESERVED_OWN: reserved_owner   <= cfg_data[OWNER_BITS-1:0];
        REG_DMA_OWN:      dma_owner        <= cfg_data[OWNER_BITS-1:0];
        REG_MONITOR_OWN:  monitor_owner    <= cfg_data[OWNER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_pfn   <= page_frame;
      req_who   <= owner_id[OWNER_BITS-1:0];
      req_flags <= '{unset:       (mode == MODE_UNSET),
                     guest_given: guest_flag_given,
                     guest_val:   guest_flag,
                     dma_given:   dma_flag_given,
                     dma_val:     dma_flag};
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      remain <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      remain <= remain_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    guest_mapped <= guest_next;
    dma_mapped   <= dma_next;
    owner        <= owner_next;
  end

  // Next state, store control and result
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    remain_next = remain;
    done_next   = 1'b0;
    status_next = ST_OK;
    guest_next  = 1'b0;
    dma_next    = 1'b0;
    owner_next  = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = rule_rec;
    ram_raddr   = idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_next  = idx_inc;
        if (idx == LW'(TRACKED_PAGES - 1)) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          remain_next = page_count;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        ram_raddr = off[AW-1:0];
        idx_next  = off[LW-1:0];
        if (req_mode != MODE_QUERY && req_mode != MODE_SET && req_mode != MODE_UNSET) begin
          done_next   = 1'b1;
          status_next = ST_INVALID;
          state_next  = S_IDLE;
        end else if (live == '0) begin
          done_next   = 1'b1;
          status_next = ST_NO_TRACKER;
          state_next  = S_IDLE;
        end else if (req_mode != MODE_QUERY && remain == '0) begin
          done_next   = 1'b1;
          status_next = ST_OK;
          state_next  = S_IDLE;
        end else if (!in_win) begin
          done_next   = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else if (req_mode == MODE_QUERY) begin
          state_next = S_QUERY;
        end else begin
          state_next = S_WALK;
        end
      end
      S_QUERY: begin
        done_next   = 1'b1;
        status_next = ST_OK;
        guest_next  = ram_rdata[OWNER_BITS];
        dma_next    = ram_rdata[OWNER_BITS+1];
        owner_next  = ID_W'(ram_rdata[OWNER_BITS-1:0]);
        state_next  = S_IDLE;
      end
      S_WALK: begin
        // Read of the following page overlaps the write-back of this one
        ram_raddr = idx_inc[AW-1:0];
        if (idx >= live) begin
          done_next   = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else if (rule_status != ST_OK) begin
          done_next   = 1'b1;
          status_next = rule_status;
          state_next  = S_IDLE;
        end else begin
          ram_we      = 1'b1;
          idx_next    = idx_inc;
          remain_next = remain - COUNT_W'(1);
          if (remain == COUNT_W'(1)) begin
            done_next   = 1'b1;
            status_next = ST_OK;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Page record store
  pot_ram #(
    .WIDTH(RW),
    .DEPTH(TRACKED_PAGES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared ownership rule unit
  pot_rule #(
    .OWNER_BITS(OWNER_BITS)
  ) u_rule (
    .cur_rec(ram_rdata),
    .who    (req_who),
    .res_own(reserved_owner),
    .dma_own(dma_owner),
    .mon_own(monitor_owner),
    .req    (req_flags),
    .new_rec(rule_rec),
    .status (rule_status)
  );

endmodule

[hdl/pot_checker.sv]
// Port-level checks for the page ownership tracker, bound to the top level.
// Depends on pot_pkg and page_ownership_tracker_core.
module pot_checker import pot_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic [2:0]      status,
  input logic            guest_mapped,
  input logic            dma_mapped,
  input logic [ID_W-1:0] owner
);

  // A result strobe always leaves the block ready for the next item.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the block busy");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_TRACKER || status == ST_REJECT ||
              status == ST_INVALID || status == ST_NOT_FOUND))
    else $error("undefined status code");

  // Record fields are zero on every result with a status other than OK.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (owner == '0 && !guest_mapped && !dma_mapped))
    else $error("record fields set on a failing result");

  // A strobe lasts one cycle, and no strobe follows directly on another.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind page_ownership_tracker_core pot_checker u_pot_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .guest_mapped(guest_mapped),
  .dma_mapped  (dma_mapped),
  .owner       (owner)
);
